@@ design/dtwr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtwr_pkg
// Types and codes shared by the ranging responder modules.
// ----------------------------------------------------------------------------
package dtwr_pkg;

  localparam int StampBits = 40;
  localparam int IdBits    = 8;
  localparam int CfgIdxBits = 2;

  // input commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_FRAME   = 2'd1;
  localparam logic [1:0] CMD_TX_DONE = 2'd2;

  // result actions
  localparam logic [2:0] ACT_REARM       = 3'd0;
  localparam logic [2:0] ACT_RESPONSE    = 3'd1;
  localparam logic [2:0] ACT_INFO        = 3'd2;
  localparam logic [2:0] ACT_RADIO_RESET = 3'd3;
  localparam logic [2:0] ACT_NONE        = 3'd4;

  // result status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ERRFRAME = 3'd1;
  localparam logic [2:0] ST_STAGE    = 3'd2;
  localparam logic [2:0] ST_RXERR    = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;
  localparam logic [2:0] ST_NOTADDR  = 3'd5;

  // session phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RESP  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  // frame stages
  localparam logic [7:0] STAGE_REQUEST = 8'd1;
  localparam logic [7:0] STAGE_FINAL   = 8'd3;

  // register indexes
  localparam logic [CfgIdxBits-1:0] REG_OWN_ID        = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_PEER_ID       = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_TIMEOUT_TICKS = 2'd2;
  localparam logic [CfgIdxBits-1:0] REG_RETRY_LIMIT   = 2'd3;

  // register reset values
  localparam logic [7:0] OWN_ID_RST        = 8'd1;
  localparam logic [7:0] PEER_ID_RST       = 8'd0;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd10;
  localparam logic [3:0] RETRY_LIMIT_RST   = 4'd3;

  typedef struct packed {
    logic [1:0]           command;
    logic                 frame_ok;
    logic [IdBits-1:0]    frame_dest;
    logic [7:0]           frame_stage;
    logic                 frame_is_error;
    logic [StampBits-1:0] stamp;
  } in_word_t;

  typedef struct packed {
    logic [2:0]           action;
    logic [2:0]           status;
    logic [IdBits-1:0]    src_id;
    logic [IdBits-1:0]    dst_id;
    logic [StampBits-1:0] round_time;
    logic [StampBits-1:0] reply_time;
  } out_word_t;

  typedef struct packed {
    logic [IdBits-1:0] own_id;
    logic [IdBits-1:0] peer_id;
    logic [7:0]        timeout_ticks;
    logic [3:0]        retry_limit;
  } cfg_t;

endpackage

@@ design/dtwr_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtwr_cfg
// Configuration register file: own id, peer id, timeout and retry limit.
// ----------------------------------------------------------------------------
module dtwr_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [dtwr_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  output dtwr_pkg::cfg_t                 cfg_o
);

  dtwr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        dtwr_pkg::REG_OWN_ID:        cfg_d.own_id        = cfg_data_i;
        dtwr_pkg::REG_PEER_ID:       cfg_d.peer_id       = cfg_data_i;
        dtwr_pkg::REG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i;
        dtwr_pkg::REG_RETRY_LIMIT:   cfg_d.retry_limit   = cfg_data_i[3:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id        <= dtwr_pkg::OWN_ID_RST;
      cfg_q.peer_id       <= dtwr_pkg::PEER_ID_RST;
      cfg_q.timeout_ticks <= dtwr_pkg::TIMEOUT_TICKS_RST;
      cfg_q.retry_limit   <= dtwr_pkg::RETRY_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/dtwr_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtwr_engine
// Session state and per-event decision logic of the ranging responder.
// ----------------------------------------------------------------------------
module dtwr_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  dtwr_pkg::in_word_t  item_i,
  input  dtwr_pkg::cfg_t      cfg_i,
  output dtwr_pkg::out_word_t result_o
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] wait_q, wait_d;
  logic [3:0] retries_q, retries_d;
  logic [dtwr_pkg::StampBits-1:0] req_stamp_q, req_stamp_d;
  logic [dtwr_pkg::StampBits-1:0] resp_stamp_q, resp_stamp_d;
  logic [dtwr_pkg::StampBits-1:0] reply_q, reply_d;

  logic       new_req;
  logic [8:0] wait_next;
  logic [4:0] retries_next;

  assign new_req = (item_i.command == dtwr_pkg::CMD_FRAME) && item_i.frame_ok &&
                   (item_i.frame_stage == dtwr_pkg::STAGE_REQUEST) &&
                   (item_i.frame_dest == cfg_i.own_id);
  assign wait_next    = {1'b0, wait_q} + 9'd1;
  assign retries_next = {1'b0, retries_q} + 5'd1;

  always_comb begin
    phase_d      = phase_q;
    wait_d       = wait_q;
    retries_d    = retries_q;
    req_stamp_d  = req_stamp_q;
    resp_stamp_d = resp_stamp_q;
    reply_d      = reply_q;
    result_o     = '0;
    result_o.action = dtwr_pkg::ACT_NONE;
    result_o.status = dtwr_pkg::ST_OK;

    case (item_i.command)
      dtwr_pkg::CMD_FRAME: begin
        if (new_req || phase_q == dtwr_pkg::PH_IDLE) begin
          // a request restarts the session from idle in any phase
          phase_d = dtwr_pkg::PH_IDLE;
          result_o.action = dtwr_pkg::ACT_REARM;
          if (!item_i.frame_ok) begin
            result_o.status = dtwr_pkg::ST_RXERR;
          end else if (item_i.frame_dest != cfg_i.own_id) begin
            result_o.status = dtwr_pkg::ST_NOTADDR;
          end else if (item_i.frame_is_error) begin
            result_o.status = dtwr_pkg::ST_ERRFRAME;
          end else if (item_i.frame_stage != dtwr_pkg::STAGE_REQUEST) begin
            result_o.status = dtwr_pkg::ST_STAGE;
          end else begin
            req_stamp_d     = item_i.stamp;
            wait_d          = '0;
            phase_d         = dtwr_pkg::PH_RESP;
            result_o.action = dtwr_pkg::ACT_RESPONSE;
            result_o.src_id = cfg_i.own_id;
            result_o.dst_id = cfg_i.peer_id;
          end
        end else if (phase_q == dtwr_pkg::PH_FINAL) begin
          retries_d = '0;
          phase_d   = dtwr_pkg::PH_IDLE;
          result_o.action = dtwr_pkg::ACT_REARM;
          if (!item_i.frame_ok) begin
            result_o.status = dtwr_pkg::ST_RXERR;
          end else if (item_i.frame_is_error) begin
            result_o.status = dtwr_pkg::ST_ERRFRAME;
          end else if (item_i.frame_stage != dtwr_pkg::STAGE_FINAL) begin
            result_o.status = dtwr_pkg::ST_STAGE;
          end else begin
            result_o.action     = dtwr_pkg::ACT_INFO;
            result_o.src_id     = cfg_i.own_id;
            result_o.dst_id     = cfg_i.peer_id;
            result_o.round_time = item_i.stamp - resp_stamp_q;
            result_o.reply_time = reply_q;
          end
        end
      end
      dtwr_pkg::CMD_TX_DONE: begin
        if (phase_q == dtwr_pkg::PH_RESP) begin
          resp_stamp_d = item_i.stamp;
          reply_d      = item_i.stamp - req_stamp_q;
          wait_d       = '0;
          phase_d      = dtwr_pkg::PH_FINAL;
        end
      end
      dtwr_pkg::CMD_TICK: begin
        if (phase_q == dtwr_pkg::PH_RESP || phase_q == dtwr_pkg::PH_FINAL) begin
          if (wait_next > {1'b0, cfg_i.timeout_ticks}) begin
            wait_d  = '0;
            phase_d = dtwr_pkg::PH_IDLE;
            result_o.status = dtwr_pkg::ST_TIMEOUT;
            if (retries_next > {1'b0, cfg_i.retry_limit}) begin
              result_o.action = dtwr_pkg::ACT_RADIO_RESET;
              retries_d       = '0;
            end else begin
              result_o.action = dtwr_pkg::ACT_REARM;
              retries_d       = retries_next[3:0];
            end
          end else begin
            wait_d = wait_next[7:0];
          end
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= dtwr_pkg::PH_IDLE;
      wait_q    <= '0;
      retries_q <= '0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      wait_q    <= wait_d;
      retries_q <= retries_d;
    end
  end

  // stamps are only read after the phase that writes them
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      req_stamp_q  <= req_stamp_d;
      resp_stamp_q <= resp_stamp_d;
      reply_q      <= reply_d;
    end
  end

endmodule

@@ design/ds_twr_responder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds_twr_responder
// Responder side of double-sided two-way ranging: one result word per event.
// ----------------------------------------------------------------------------
// Path: an accepted event word sits in the input reg, which feeds the decision
//   logic; the result reg loads the result when the held word advances.
// Throughput: one event word per cycle; the session update is one pass of
//   decision logic and a 40-bit subtract between the two registers. The input
//   stalls only while both registers are full and the result is held.
// Reset: session idle, counters cleared, registers at their defaults; the
//   config port is always ready.
module ds_twr_responder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dtwr_pkg::in_word_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dtwr_pkg::out_word_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dtwr_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  dtwr_pkg::cfg_t      cfg;
  dtwr_pkg::in_word_t  in_q;
  dtwr_pkg::out_word_t result, out_q;
  logic                in_valid_q, out_valid_q, advance, in_accept;

  assign cfg_ready_o = 1'b1;

  dtwr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // move the held word into the result register when that slot frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  dtwr_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives radio events (ticks, received frames, transmit-done) into the
// ranging responder and checks every result word against an in-bench session
// model: directed idle and session cases, back-pressure, retry exhaustion,
// then random sessions under several register settings with random gaps on
// both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int StampW = dtwr_pkg::StampBits;

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            ev_valid  = 1'b0;
  logic                            ev_stall;
  dtwr_pkg::in_word_t              ev_word   = '0;
  logic                            res_valid;
  logic                            res_stall = 1'b0;
  dtwr_pkg::out_word_t             res_word;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dtwr_pkg::CfgIdxBits-1:0] cfg_index = dtwr_pkg::REG_OWN_ID;
  logic [7:0]                      cfg_data  = '0;

  // session model
  dtwr_pkg::cfg_t        cfg_m;
  logic [1:0]            session_phase;
  logic [StampW-1:0]     req_stamp;
  logic [StampW-1:0]     resp_stamp;
  logic [StampW-1:0]     reply_span;
  logic [7:0]            tick_count;
  logic [3:0]            retry_tally;

  dtwr_pkg::out_word_t   radio_actions_due[$];
  int unsigned           acted_events;
  int unsigned           error_count;
  int unsigned           results_seen;

  // channel pacing
  bit                    tx_jitter;
  bit                    rx_jitter;
  int unsigned           hold_request;
  int unsigned           hold_left;
  int unsigned           run_left;
  bit                    run_stalled;

  ds_twr_responder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (ev_valid),
    .in_stall_o  (ev_stall),
    .in_data_i   (ev_word),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

  // Work out the result word for one event and advance the session model.
  function automatic dtwr_pkg::out_word_t next_radio_action(dtwr_pkg::in_word_t ev);
    dtwr_pkg::out_word_t r;
    logic [8:0]          next_tick;
    logic [4:0]          next_retry;
    r        = '0;
    r.action = dtwr_pkg::ACT_NONE;
    r.status = dtwr_pkg::ST_OK;
    case (ev.command)
      dtwr_pkg::CMD_FRAME: begin
        if (ev.frame_ok && ev.frame_stage == dtwr_pkg::STAGE_REQUEST &&
            ev.frame_dest == cfg_m.own_id)
          session_phase = dtwr_pkg::PH_IDLE;
        if (session_phase == dtwr_pkg::PH_IDLE) begin
          r.action = dtwr_pkg::ACT_REARM;
          if (!ev.frame_ok) r.status = dtwr_pkg::ST_RXERR;
          else if (ev.frame_dest != cfg_m.own_id) r.status = dtwr_pkg::ST_NOTADDR;
          else if (ev.frame_is_error) r.status = dtwr_pkg::ST_ERRFRAME;
          else if (ev.frame_stage != dtwr_pkg::STAGE_REQUEST) r.status = dtwr_pkg::ST_STAGE;
          else begin
            req_stamp     = ev.stamp;
            tick_count    = '0;
            session_phase = dtwr_pkg::PH_RESP;
            r.action      = dtwr_pkg::ACT_RESPONSE;
            r.src_id      = cfg_m.own_id;
            r.dst_id      = cfg_m.peer_id;
          end
        end else if (session_phase == dtwr_pkg::PH_FINAL) begin
          // any frame ends the final wait; destination is not checked here
          retry_tally   = '0;
          session_phase = dtwr_pkg::PH_IDLE;
          r.action      = dtwr_pkg::ACT_REARM;
          if (!ev.frame_ok) r.status = dtwr_pkg::ST_RXERR;
          else if (ev.frame_is_error) r.status = dtwr_pkg::ST_ERRFRAME;
          else if (ev.frame_stage != dtwr_pkg::STAGE_FINAL) r.status = dtwr_pkg::ST_STAGE;
          else begin
            r.action     = dtwr_pkg::ACT_INFO;
            r.src_id     = cfg_m.own_id;
            r.dst_id     = cfg_m.peer_id;
            r.round_time = ev.stamp - resp_stamp;
            r.reply_time = reply_span;
          end
        end
      end
      dtwr_pkg::CMD_TX_DONE: begin
        if (session_phase == dtwr_pkg::PH_RESP) begin
          resp_stamp    = ev.stamp;
          reply_span    = ev.stamp - req_stamp;
          tick_count    = '0;
          session_phase = dtwr_pkg::PH_FINAL;
        end
      end
      dtwr_pkg::CMD_TICK: begin
        if (session_phase == dtwr_pkg::PH_RESP || session_phase == dtwr_pkg::PH_FINAL) begin
          next_tick = {1'b0, tick_count} + 9'd1;
          if (next_tick > {1'b0, cfg_m.timeout_ticks}) begin
            r.action   = dtwr_pkg::ACT_REARM;
            r.status   = dtwr_pkg::ST_TIMEOUT;
            next_retry = {1'b0, retry_tally} + 5'd1;
            if (next_retry > {1'b0, cfg_m.retry_limit}) begin
              r.action   = dtwr_pkg::ACT_RADIO_RESET;
              next_retry = '0;
            end
            retry_tally   = next_retry[3:0];
            tick_count    = '0;
            session_phase = dtwr_pkg::PH_IDLE;
          end else begin
            tick_count = next_tick[7:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [StampW-1:0] rand_stamp();
    case ($urandom_range(0, 7))
      0:       return StampW'($urandom_range(0, 255));
      1:       return '1 - StampW'($urandom_range(0, 255));
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic dtwr_pkg::in_word_t scrambled();
    dtwr_pkg::in_word_t ev;
    ev.command        = dtwr_pkg::CMD_TICK;
    ev.frame_ok       = 1'($urandom);
    ev.frame_dest     = 8'($urandom);
    ev.frame_stage    = 8'($urandom);
    ev.frame_is_error = 1'($urandom);
    ev.stamp          = rand_stamp();
    return ev;
  endfunction

  function automatic dtwr_pkg::in_word_t tick_event();
    return scrambled();
  endfunction

  function automatic dtwr_pkg::in_word_t tx_event(logic [StampW-1:0] stamp);
    dtwr_pkg::in_word_t ev;
    ev         = scrambled();
    ev.command = dtwr_pkg::CMD_TX_DONE;
    ev.stamp   = stamp;
    return ev;
  endfunction

  function automatic dtwr_pkg::in_word_t frame_event(logic ok, logic [7:0] dest,
                                                     logic [7:0] stage, logic is_err,
                                                     logic [StampW-1:0] stamp);
    dtwr_pkg::in_word_t ev;
    ev.command        = dtwr_pkg::CMD_FRAME;
    ev.frame_ok       = ok;
    ev.frame_dest     = dest;
    ev.frame_stage    = stage;
    ev.frame_is_error = is_err;
    ev.stamp          = stamp;
    return ev;
  endfunction

  // Offer one word, hold it until accepted, then queue its expected result.
  task automatic send_event(dtwr_pkg::in_word_t ev);
    dtwr_pkg::out_word_t due;
    int unsigned         gap;
    bit                  stalled;
    gap = 0;
    if (tx_jitter) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 55) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(8, 24);
    end
    if (gap != 0) begin
      ev_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_valid <= 1'b1;
    ev_word  <= ev;
    do begin
      @(negedge clk);
      stalled = ev_stall;
      @(posedge clk);
    end while (stalled);
    due = next_radio_action(ev);
    radio_actions_due.push_back(due);
    if (due.action != dtwr_pkg::ACT_NONE) acted_events++;
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_event(tick_event());
  endtask

  // Ticks that stay within the timeout of the current setting.
  function automatic int unsigned quiet_ticks();
    return $urandom_range(0, (cfg_m.timeout_ticks > 3) ? 3 : cfg_m.timeout_ticks);
  endfunction

  // Drop valid and wait until every expected word has come back.
  task automatic settle();
    int unsigned waited;
    ev_valid <= 1'b0;
    waited = 0;
    while (radio_actions_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [dtwr_pkg::CfgIdxBits-1:0] idx, logic [7:0] val);
    bit busy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      busy = !cfg_ready;
      @(posedge clk);
    end while (busy);
    cfg_valid <= 1'b0;
    case (idx)
      dtwr_pkg::REG_OWN_ID:        cfg_m.own_id        = val;
      dtwr_pkg::REG_PEER_ID:       cfg_m.peer_id       = val;
      dtwr_pkg::REG_TIMEOUT_TICKS: cfg_m.timeout_ticks = val;
      dtwr_pkg::REG_RETRY_LIMIT:   cfg_m.retry_limit   = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [7:0] anchor, logic [7:0] peer, logic [7:0] ticks,
                                logic [3:0] retries);
    settle();
    write_reg(dtwr_pkg::REG_OWN_ID, anchor);
    write_reg(dtwr_pkg::REG_PEER_ID, peer);
    write_reg(dtwr_pkg::REG_TIMEOUT_TICKS, ticks);
    write_reg(dtwr_pkg::REG_RETRY_LIMIT, {4'd0, retries});
  endtask

  // Request, optional response done, then enough ticks to time out.
  task automatic play_abandoned();
    send_event(frame_event(1'b1, cfg_m.own_id, dtwr_pkg::STAGE_REQUEST, 1'b0, rand_stamp()));
    if ($urandom_range(0, 1)) send_event(tx_event(rand_stamp()));
    send_ticks(int'(cfg_m.timeout_ticks) + 1 + $urandom_range(0, 1));
  endtask

  task automatic play_session();
    int unsigned        pick;
    logic [StampW-1:0]  t_req;
    logic [StampW-1:0]  t_tx;
    dtwr_pkg::in_word_t ev;
    pick  = $urandom_range(0, 99);
    t_req = rand_stamp();
    if (pick < 60) begin
      send_event(frame_event(1'b1, cfg_m.own_id, dtwr_pkg::STAGE_REQUEST, 1'b0, t_req));
      send_ticks(quiet_ticks());
      if ($urandom_range(0, 4) == 0) begin
        ev         = scrambled();
        ev.command = dtwr_pkg::CMD_FRAME;
        send_event(ev);
      end
      t_tx = ($urandom_range(0, 3) == 0) ? rand_stamp()
                                         : t_req + StampW'($urandom_range(100, 100000));
      send_event(tx_event(t_tx));
      send_ticks(quiet_ticks());
      ev = frame_event(1'b1, cfg_m.own_id, dtwr_pkg::STAGE_FINAL, 1'b0,
                       ($urandom_range(0, 3) == 0) ? rand_stamp()
                                                   : t_tx + StampW'($urandom));
      if ($urandom_range(0, 4) == 0) ev.frame_dest = 8'($urandom);
      send_event(ev);
    end else if (pick < 75) begin
      play_abandoned();
    end else if (pick < 90) begin
      send_event(frame_event(1'b1, cfg_m.own_id, dtwr_pkg::STAGE_REQUEST, 1'b0, t_req));
      if ($urandom_range(0, 3) != 0) send_event(tx_event(rand_stamp()));
      ev = frame_event(1'b1, cfg_m.own_id, dtwr_pkg::STAGE_FINAL, 1'b0, rand_stamp());
      case ($urandom_range(0, 3))
        0: ev.frame_ok = 1'b0;
        1: ev.frame_is_error = 1'b1;
        2: ev.frame_stage = 8'($urandom);
        default: begin
          ev.frame_stage    = dtwr_pkg::STAGE_REQUEST;
          ev.frame_is_error = 1'b1;
        end
      endcase
      send_event(ev);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        ev = scrambled();
        ev.command = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) ev.frame_dest = cfg_m.own_id;
        if ($urandom_range(0, 1))
          ev.frame_stage = $urandom_range(0, 1) ? dtwr_pkg::STAGE_REQUEST
                                                : dtwr_pkg::STAGE_FINAL;
        send_event(ev);
      end
    end
  endtask

  task automatic run_random_sessions(int unsigned quota);
    int unsigned start;
    start = acted_events;
    while (acted_events - start < quota) play_session();
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_idle_and_session();
    logic [7:0] me;
    me        = cfg_m.own_id;
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    send_event(tick_event());
    send_event(tx_event('1));
    send_event(frame_event(1'b0, me, dtwr_pkg::STAGE_REQUEST, 1'b0, '0));
    send_event(frame_event(1'b1, 8'd255, dtwr_pkg::STAGE_REQUEST, 1'b0, '1));
    send_event(frame_event(1'b1, 8'd0, dtwr_pkg::STAGE_REQUEST, 1'b0, '0));
    send_event(frame_event(1'b1, me, dtwr_pkg::STAGE_REQUEST, 1'b1, '0));
    send_event(frame_event(1'b1, me, 8'd0, 1'b0, '0));
    send_event(frame_event(1'b1, me, 8'd255, 1'b0, '1));
    send_event(frame_event(1'b1, me, dtwr_pkg::STAGE_FINAL, 1'b0, '0));
    // wrap both stamp differences across zero
    send_event(frame_event(1'b1, me, dtwr_pkg::STAGE_REQUEST, 1'b0, 40'hFF_FFFF_FFF0));
    send_event(frame_event(1'b1, me, dtwr_pkg::STAGE_FINAL, 1'b0, '0));
    send_event(tick_event());
    send_event(tx_event(40'h10));
    send_event(tx_event(40'h55));
    send_event(frame_event(1'b1, 8'd255, dtwr_pkg::STAGE_FINAL, 1'b0, 40'h5));
    // restart while waiting for transmit done and while waiting for the final
    send_event(frame_event(1'b1, me, dtwr_pkg::STAGE_REQUEST, 1'b0, '0));
    send_event(frame_event(1'b1, me, dtwr_pkg::STAGE_REQUEST, 1'b0, 40'd100));
    send_event(tx_event(40'd1000));
    send_event(frame_event(1'b1, me, dtwr_pkg::STAGE_REQUEST, 1'b0, 40'd2000));
    send_event(tx_event('1));
    send_event(frame_event(1'b0, me, dtwr_pkg::STAGE_FINAL, 1'b0, '1));
    send_event(frame_event(1'b1, me, dtwr_pkg::STAGE_REQUEST, 1'b0, 40'd7));
    send_event(tx_event(40'd9));
    send_event(frame_event(1'b1, me, dtwr_pkg::STAGE_FINAL, 1'b1, 40'd11));
    send_event(frame_event(1'b1, me, dtwr_pkg::STAGE_REQUEST, 1'b0, 40'd7));
    send_event(tx_event(40'd9));
    send_event(frame_event(1'b1, me, 8'd2, 1'b0, 40'd11));
    settle();
  endtask

  task automatic test_backpressure();
    tx_jitter    = 1'b0;
    rx_jitter    = 1'b0;
    hold_request = 160;
    // keep offering while results are held back
    repeat (8) play_session();
    settle();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    run_random_sessions(20);
    settle();
    tx_jitter = 1'b0;
    run_random_sessions(15);
    tx_jitter = 1'b1;
    rx_jitter = 1'b0;
    run_random_sessions(15);
  endtask

  task automatic test_retry_exhaustion();
    apply_settings(8'd0, 8'd255, 8'd1, 4'd15);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    repeat (17) play_abandoned();
    run_random_sessions(20);
  endtask

  task automatic test_random_traffic();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    apply_settings(8'd0, 8'd255, 8'd1, 4'd0);
    run_random_sessions(110);
    apply_settings(8'd255, 8'd0, 8'd4, 4'd15);
    run_random_sessions(110);
    repeat (2) begin
      apply_settings(8'($urandom), 8'($urandom), 8'($urandom_range(2, 12)),
                     4'($urandom_range(0, 15)));
      run_random_sessions(80);
    end
    apply_settings(8'd255, 8'd255, 8'd255, 4'd2);
    run_random_sessions(12);
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      res_stall <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (!rx_jitter) begin
        res_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stalled = !run_stalled;
          if (run_stalled)
            run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                    : $urandom_range(8, 24);
          else
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
        end
        run_left--;
        res_stall <= run_stalled;
      end
    end
  end

  // Values seen at the falling edge are the ones the next rising edge takes.
  always @(negedge clk) begin
    dtwr_pkg::out_word_t want;
    if (rst_n && res_valid && !res_stall) begin
      results_seen++;
      if (radio_actions_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("result %0d unexpected: act=%0d st=%0d src=%0h dst=%0h rt=%0h rp=%0h",
                   results_seen, res_word.action, res_word.status, res_word.src_id,
                   res_word.dst_id, res_word.round_time, res_word.reply_time);
      end else begin
        want = radio_actions_due.pop_front();
        if (res_word.action !== want.action || res_word.status !== want.status ||
            res_word.src_id !== want.src_id || res_word.dst_id !== want.dst_id ||
            res_word.round_time !== want.round_time ||
            res_word.reply_time !== want.reply_time) begin
          error_count++;
          if (error_count <= 10)
            $display({"result %0d mismatch: exp act=%0d st=%0d src=%0h dst=%0h rt=%0h ",
                      "rp=%0h / got act=%0d st=%0d src=%0h dst=%0h rt=%0h rp=%0h"},
                     results_seen, want.action, want.status, want.src_id, want.dst_id,
                     want.round_time, want.reply_time, res_word.action, res_word.status,
                     res_word.src_id, res_word.dst_id, res_word.round_time,
                     res_word.reply_time);
        end
      end
    end
  end

  initial begin : main_flow
    cfg_m.own_id        = dtwr_pkg::OWN_ID_RST;
    cfg_m.peer_id       = dtwr_pkg::PEER_ID_RST;
    cfg_m.timeout_ticks = dtwr_pkg::TIMEOUT_TICKS_RST;
    cfg_m.retry_limit   = dtwr_pkg::RETRY_LIMIT_RST;
    session_phase       = dtwr_pkg::PH_IDLE;
    req_stamp           = '0;
    resp_stamp          = '0;
    reply_span          = '0;
    tick_count          = '0;
    retry_tally         = '0;
    acted_events        = 0;
    error_count         = 0;
    results_seen        = 0;
    tx_jitter           = 1'b0;
    rx_jitter           = 1'b0;
    hold_request        = 0;
    hold_left           = 0;
    run_left            = 0;
    run_stalled         = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_session();
    test_backpressure();
    test_retry_exhaustion();
    test_random_traffic();
    settle();
    if (radio_actions_due.size() != 0) begin
      $display("%0d expected result words never arrived", radio_actions_due.size());
      error_count += radio_actions_due.size();
    end
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/dtwr_pkg.sv
design/dtwr_cfg.sv
design/dtwr_engine.sv
design/ds_twr_responder.sv
test/testbench.sv
